### sv/pplhm_pkg.sv
package pplhm_pkg;

   localparam int PathCount = 5;
   localparam int BinCount  = 32;
   localparam int TableLen  = 32;
   localparam logic [19:0] MaxLatUs = 20'd1000000;

   typedef enum logic [1:0] {
      ACT_DELIVERED = 2'd0,
      ACT_FILTERED  = 2'd1,
      ACT_BOTTLENECK = 2'd2,
      ACT_SPARE     = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_LAUNCH,
      ST_DIV_TP,
      ST_DIV_EFF,
      ST_DIV_LOSS,
      ST_DIV_MEAN,
      ST_DIV_MSQ,
      ST_SQRT,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic div_start;
      logic [2:0] div_sel;
      logic sqrt_start;
      logic walk_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic path_ok;
      logic div_done;
      logic sqrt_done;
      logic walk_done;
   } status_type;

   localparam logic [2:0] DIV_TP   = 3'd0;
   localparam logic [2:0] DIV_EFF  = 3'd1;
   localparam logic [2:0] DIV_LOSS = 3'd2;
   localparam logic [2:0] DIV_MEAN = 3'd3;
   localparam logic [2:0] DIV_MSQ  = 3'd4;

   function automatic logic [19:0] lat_bin_base(input logic [5:0] idx);
      logic [19:0] r;
      begin
         case (idx)
            6'd0: r = 20'd1;       6'd1: r = 20'd2;       6'd2: r = 20'd3;
            6'd3: r = 20'd4;       6'd4: r = 20'd6;       6'd5: r = 20'd10;
            6'd6: r = 20'd15;      6'd7: r = 20'd23;      6'd8: r = 20'd36;
            6'd9: r = 20'd56;      6'd10: r = 20'd87;     6'd11: r = 20'd135;
            6'd12: r = 20'd211;    6'd13: r = 20'd329;    6'd14: r = 20'd513;
            6'd15: r = 20'd801;    6'd16: r = 20'd1250;   6'd17: r = 20'd1952;
            6'd18: r = 20'd3047;   6'd19: r = 20'd4758;   6'd20: r = 20'd7430;
            6'd21: r = 20'd11602;  6'd22: r = 20'd18117;  6'd23: r = 20'd28289;
            6'd24: r = 20'd44174;  6'd25: r = 20'd68978;  6'd26: r = 20'd107711;
            6'd27: r = 20'd168193; 6'd28: r = 20'd262637; 6'd29: r = 20'd410113;
            6'd30: r = 20'd640401; 6'd31: r = 20'd1000000;
            default: r = 20'hFFFFF;
         endcase
         return r;
      end
   endfunction

endpackage

### sv/pplhm_ctrl.sv
module pplhm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pplhm_pkg::status_type  status,
   output pplhm_pkg::cmd_type     cmd
);
   import pplhm_pkg::*;

   state_type state_ff, state_in;
   logic [2:0] sel_ff, sel_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= DIV_TP;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // sequence one event: read, update, five divisions, root, walks, emit; a bad path ends at read
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.div_sel = sel_ff;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.path_ok) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LAUNCH;
         end
         // start the first division once the totals hold the event
         ST_LAUNCH: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TP;
            sel_in        = DIV_TP;
            state_in      = ST_DIV_TP;
         end
         ST_DIV_TP, ST_DIV_EFF, ST_DIV_LOSS, ST_DIV_MEAN: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               sel_in        = sel_ff + 3'd1;
               cmd.div_sel   = sel_ff + 3'd1;
               state_in      = state_type'(state_ff + 4'd1);
            end
         end
         ST_DIV_MSQ: begin
            if (status.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### sv/pplhm_div.sv
module pplhm_div (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [79:0]   dividend,
   input  logic [63:0]   divisor,
   output logic [79:0]   quotient,
   output logic          done
);
   logic [79:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[63:0], quo_ff[79]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = 7'd80;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[64]) begin
            rem_in = trial;
            quo_in = {quo_ff[78:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### sv/pplhm_dp.sv
module pplhm_dp #(
   parameter int PATH_COUNT = pplhm_pkg::PathCount,
   parameter int BIN_COUNT  = pplhm_pkg::BinCount
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pplhm_pkg::cmd_type    cmd,
   output pplhm_pkg::status_type status,
   input  logic                  lat_en,
   input  logic [1:0]            action,
   input  logic [2:0]            path_id,
   input  logic [23:0]           info_bits,
   input  logic [23:0]           latency,
   input  logic [47:0]           now_time,
   output logic                  out_valid,
   output logic [2:0]            path_out,
   output logic [31:0]           throughput,
   output logic [16:0]           efficiency,
   output logic [14:0]           loss_percent,
   output logic [23:0]           mean_latency,
   output logic [23:0]           latency_deviation,
   output logic [19:0]           median_latency,
   output logic [19:0]           p90_latency,
   output logic [19:0]           p99_latency,
   output logic [23:0]           least_latency,
   output logic [23:0]           greatest_latency
);
   import pplhm_pkg::*;

   localparam int PW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
   localparam int BU = (BIN_COUNT < TableLen) ? BIN_COUNT : TableLen;
   localparam int BW = $clog2(BIN_COUNT);
   localparam int HD = PATH_COUNT * BIN_COUNT;
   localparam int HW = $clog2(HD);

   // per-path counters
   logic [31:0] dcnt_ff  [PATH_COUNT];
   logic [47:0] dbits_ff [PATH_COUNT];
   logic [47:0] fbits_ff [PATH_COUNT];
   logic [63:0] lsum_ff  [PATH_COUNT];
   logic [63:0] lsq_ff   [PATH_COUNT];
   logic [23:0] lmin_ff  [PATH_COUNT];
   logic [23:0] lmax_ff  [PATH_COUNT];
   logic [31:0] scnt_ff  [PATH_COUNT];
   logic [31:0] hist_mem [HD];
   logic [BIN_COUNT-1:0] hvalid_ff [PATH_COUNT];

   // latched event
   logic [1:0]  act_ff;
   logic [2:0]  path_ff;
   logic [PW-1:0] p;
   logic [23:0] bits_ff, lat_ff;
   logic [47:0] now_ff;
   logic [47:0] lsqr_ff;
   logic [BW-1:0] bin_ff;
   logic        sample_ff;

   logic [47:0] d_ff, f_ff;
   logic [31:0] n_ff, s_ff;
   logic [63:0] ls_ff, lq_ff;
   logic [23:0] mn_ff, mx_ff;

   assign p = path_ff[PW-1:0];

   // find the bin of the latency
   logic [BW-1:0] bin_c;
   always_comb begin
      bin_c = '0;
      for (int i = 1; i < BU; i++) begin
         if ({8'd0, latency} >= {12'd0, lat_bin_base(6'(i))}) bin_c = BW'(i);
      end
   end

   // capture event
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= action;
         path_ff   <= path_id;
         bits_ff   <= info_bits;
         lat_ff    <= latency;
         now_ff    <= now_time;
         bin_ff    <= bin_c;
         sample_ff <= (action == ACT_DELIVERED) && lat_en && (latency != 24'd0);
      end
      lsqr_ff <= lat_ff * lat_ff;
   end

   assign status.path_ok = ({29'd0, path_ff} < 32'(PATH_COUNT));

   logic deliv, filt;
   assign deliv = (act_ff == ACT_DELIVERED);
   assign filt  = (act_ff == ACT_FILTERED);

   logic [48:0] dsum, fsum;
   logic [64:0] lsum_n, lsq_n;
   logic [32:0] dcnt_n, scnt_n;
   assign dsum   = {1'b0, dbits_ff[p]} + {25'd0, bits_ff};
   assign fsum   = {1'b0, fbits_ff[p]} + {25'd0, bits_ff};
   assign lsum_n = {1'b0, lsum_ff[p]} + {41'd0, lat_ff};
   assign lsq_n  = {1'b0, lsq_ff[p]} + {17'd0, lsqr_ff};
   assign dcnt_n = {1'b0, dcnt_ff[p]} + 33'd1;
   assign scnt_n = {1'b0, scnt_ff[p]} + 33'd1;

   // update per-path totals, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATH_COUNT; i++) begin
            dcnt_ff[i]   <= '0;
            dbits_ff[i]  <= '0;
            fbits_ff[i]  <= '0;
            lsum_ff[i]   <= '0;
            lsq_ff[i]    <= '0;
            lmin_ff[i]   <= '1;
            lmax_ff[i]   <= '0;
            scnt_ff[i]   <= '0;
            hvalid_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         if (deliv) begin
            dcnt_ff[p]  <= dcnt_n[32] ? '1 : dcnt_n[31:0];
            dbits_ff[p] <= dsum[48] ? '1 : dsum[47:0];
            if (sample_ff) begin
               lsum_ff[p] <= lsum_n[64] ? '1 : lsum_n[63:0];
               lsq_ff[p]  <= lsq_n[64] ? '1 : lsq_n[63:0];
               if (lat_ff < lmin_ff[p]) lmin_ff[p] <= lat_ff;
               if (lat_ff > lmax_ff[p]) lmax_ff[p] <= lat_ff;
               scnt_ff[p] <= scnt_n[32] ? '1 : scnt_n[31:0];
               hvalid_ff[p][bin_ff] <= 1'b1;
            end
         end else if (filt) begin
            fbits_ff[p] <= fsum[48] ? '1 : fsum[47:0];
         end
      end
   end

   // histogram memory: read in READ, write back in UPDATE, walk later
   logic [HW-1:0] haddr;
   logic [31:0]   hrd_ff;
   logic [BW-1:0] walk_idx_ff, walk_idx_in;
   logic          hv_rd_ff;
   logic          walk_ff;
   logic [HW:0]   addr_ext;
   assign addr_ext = walk_ff ? ((HW+1)'(p) * (HW+1)'(BIN_COUNT) + (HW+1)'(walk_idx_ff))
                             : ((HW+1)'(p) * (HW+1)'(BIN_COUNT) + (HW+1)'(bin_ff));
   assign haddr = addr_ext[HW-1:0];

   logic [32:0] hinc;
   assign hinc = {1'b0, hv_rd_ff ? hrd_ff : 32'd0} + 33'd1;

   always_ff @(posedge clock) begin
      if (cmd.update && deliv && sample_ff) begin
         hist_mem[haddr] <= hinc[32] ? '1 : hinc[31:0];
      end
      hrd_ff <= hist_mem[haddr];
      hv_rd_ff <= hvalid_ff[p][walk_ff ? walk_idx_ff : bin_ff];
   end

   // snapshot after the update
   always_ff @(posedge clock) begin
      if (cmd.div_start && cmd.div_sel == DIV_TP) begin
         d_ff  <= dbits_ff[p];
         f_ff  <= fbits_ff[p];
         n_ff  <= dcnt_ff[p];
         s_ff  <= scnt_ff[p];
         ls_ff <= lsum_ff[p];
         lq_ff <= lsq_ff[p];
         mn_ff <= lmin_ff[p];
         mx_ff <= lmax_ff[p];
      end
   end

   // shared divider operand select
   logic [79:0] dvd;
   logic [63:0] dvs;
   logic [79:0] quo;
   logic [48:0] tot;
   logic [47:0] dsel, fsel;
   logic [31:0] nsel;
   logic [63:0] lssel, lqsel;
   assign dsel  = (cmd.div_sel == DIV_TP) ? dbits_ff[p] : d_ff;
   assign fsel  = fbits_ff[p];
   assign nsel  = dcnt_ff[p];
   assign lssel = ls_ff;
   assign lqsel = lq_ff;
   assign tot   = {1'b0, d_ff} + {1'b0, f_ff};

   always_comb begin
      dvd = '0;
      dvs = 64'd1;
      case (cmd.div_sel)
         DIV_TP: begin
            dvd = {32'd0, dsel} * 80'd15625;
            dvs = {14'd0, now_ff, 2'b00};
         end
         DIV_EFF: begin
            dvd = {16'd0, d_ff, 16'd0};
            dvs = {15'd0, tot};
         end
         DIV_LOSS: begin
            dvd = {32'd0, fsel} * 80'd25600;
            dvs = {15'd0, tot};
         end
         DIV_MEAN: begin
            dvd = {16'd0, lssel};
            dvs = {32'd0, nsel};
         end
         DIV_MSQ: begin
            dvd = {16'd0, lqsel};
            dvs = {32'd0, nsel};
         end
         default: begin
            dvd = '0;
            dvs = 64'd1;
         end
      endcase
   end

   logic [2:0] cur_sel_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) cur_sel_ff <= cmd.div_sel;
   end

   pplhm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quo),
      .done     (status.div_done)
   );

   // collect quotients; the mean-square quotient feeds the root directly
   logic [31:0] tp_ff;
   logic [16:0] eff_ff;
   logic [14:0] loss_ff;
   logic [63:0] m_ff;
   always_ff @(posedge clock) begin
      if (status.div_done) begin
         case (cur_sel_ff)
            DIV_TP:   tp_ff   <= (now_ff == 48'd0) ? 32'd0 :
                                 ((|quo[79:32]) ? '1 : quo[31:0]);
            DIV_EFF:  eff_ff  <= (tot == 49'd0) ? 17'd0 : quo[16:0];
            DIV_LOSS: loss_ff <= (tot == 49'd0) ? 15'd0 : quo[14:0];
            DIV_MEAN: m_ff    <= quo[63:0];
            default:  tp_ff   <= tp_ff;
         endcase
      end
   end

   // variance: clamp mean then square (one 32x32 multiply)
   logic [31:0] mc;
   logic [63:0] mcsq_ff;
   assign mc = (|m_ff[63:32]) ? '1 : m_ff[31:0];
   always_ff @(posedge clock) begin
      mcsq_ff <= mc * mc;
   end

   // integer square root, two bits per cycle
   logic [63:0] sv_ff, sr_ff, sb_ff;
   logic        srun_ff, sdone_ff;
   logic [64:0] sacc;
   assign sacc = {1'b0, sr_ff} + {1'b0, sb_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         srun_ff  <= 1'b0;
         sdone_ff <= 1'b0;
      end else begin
         sdone_ff <= 1'b0;
         if (cmd.sqrt_start) begin
            sv_ff   <= (quo[63:0] > mcsq_ff) ? quo[63:0] - mcsq_ff : 64'd0;
            sr_ff   <= '0;
            sb_ff   <= 64'h4000_0000_0000_0000;
            srun_ff <= 1'b1;
         end else if (srun_ff) begin
            if ({1'b0, sv_ff} >= sacc) begin
               sv_ff <= sv_ff - sacc[63:0];
               sr_ff <= (sr_ff >> 1) + sb_ff;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sb_ff <= sb_ff >> 2;
            if (sb_ff[0]) begin
               srun_ff  <= 1'b0;
               sdone_ff <= 1'b1;
            end
         end
      end
   end
   assign status.sqrt_done = sdone_ff;

   // percentile targets kept as n*P: a running count exceeds floor(n*P/100)
   // exactly when 100 times the count exceeds n*P, all three walked at once
   logic [38:0] t50, t90, t99;
   always_comb begin
      t50 = {7'd0, s_ff} * 39'd50;
      t90 = {7'd0, s_ff} * 39'd90;
      t99 = {7'd0, s_ff} * 39'd99;
   end

   logic [38:0] t50_ff, t90_ff, t99_ff;
   logic [38:0] cum_ff;
   logic [19:0] q50_ff, q90_ff, q99_ff;
   logic        h50_ff, h90_ff, h99_ff;
   logic        wpend_ff, wdone_ff;
   logic [38:0] cum_n;
   logic [45:0] cum100;
   logic [19:0] wstart, clampmax;
   assign cum_n   = cum_ff + {7'd0, hv_rd_ff ? hrd_ff : 32'd0};
   assign cum100  = {7'd0, cum_n} * 46'd100;
   assign wstart  = lat_bin_base(6'(walk_idx_ff));
   assign clampmax = ({4'd0, mx_ff} > {4'd0, MaxLatUs}) ? MaxLatUs : mx_ff[19:0];
   assign walk_idx_in = walk_idx_ff + BW'(1);

   // walk bins: address, then accumulate on registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff  <= 1'b0;
         wpend_ff <= 1'b0;
         wdone_ff <= 1'b0;
      end else begin
         wdone_ff <= 1'b0;
         if (cmd.walk_start) begin
            walk_ff     <= 1'b1;
            wpend_ff    <= 1'b0;
            walk_idx_ff <= '0;
            cum_ff      <= '0;
            t50_ff      <= t50;
            t90_ff      <= t90;
            t99_ff      <= t99;
            h50_ff <= 1'b0; h90_ff <= 1'b0; h99_ff <= 1'b0;
         end else if (walk_ff && !wpend_ff) begin
            wpend_ff <= 1'b1;
         end else if (walk_ff) begin
            wpend_ff <= 1'b0;
            cum_ff   <= cum_n;
            if (!h50_ff && cum100 > {7'd0, t50_ff}) begin
               h50_ff <= 1'b1; q50_ff <= wstart;
            end
            if (!h90_ff && cum100 > {7'd0, t90_ff}) begin
               h90_ff <= 1'b1; q90_ff <= wstart;
            end
            if (!h99_ff && cum100 > {7'd0, t99_ff}) begin
               h99_ff <= 1'b1; q99_ff <= wstart;
            end
            if (32'(walk_idx_ff) == 32'(BU - 1)) begin
               walk_ff  <= 1'b0;
               wdone_ff <= 1'b1;
            end else begin
               walk_idx_ff <= walk_idx_in;
            end
         end
      end
   end
   assign status.walk_done = wdone_ff;

   // result register
   logic nz;
   assign nz = (n_ff != 32'd0);
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= cmd.emit;
      end
      if (cmd.emit) begin
         path_out          <= path_ff;
         throughput        <= tp_ff;
         efficiency        <= eff_ff;
         loss_percent      <= loss_ff;
         mean_latency      <= !nz ? 24'd0 : ((|m_ff[63:24]) ? '1 : m_ff[23:0]);
         latency_deviation <= !nz ? 24'd0 : ((|sr_ff[63:24]) ? '1 : sr_ff[23:0]);
         median_latency    <= (!nz || s_ff == 32'd0) ? 20'd0 : (h50_ff ? q50_ff : clampmax);
         p90_latency       <= (!nz || s_ff == 32'd0) ? 20'd0 : (h90_ff ? q90_ff : clampmax);
         p99_latency       <= (!nz || s_ff == 32'd0) ? 20'd0 : (h99_ff ? q99_ff : clampmax);
         least_latency     <= mn_ff;
         greatest_latency  <= mx_ff;
      end
   end

endmodule

### sv/per_path_latency_histogram_monitor.sv
// From the start transfer to the rsp_valid strobe the block steps through read, update and
// launch, five passes of the shared restoring divider, a square root, a bin walk that
// addresses and then accumulates each bin, and an emit state.
// No new event is taken while busy; busy drops in the cycle the result is strobed.
// An out-of-range path holds busy for one cycle and gives no result. Reset (synchronous,
// active high) clears totals and histogram valid bits; the receiver cannot stall results.
module per_path_latency_histogram_monitor #(
   parameter int PATH_COUNT = pplhm_pkg::PathCount,
   parameter int BIN_COUNT  = pplhm_pkg::BinCount
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_path_id,
   input  logic [23:0] req_info_bits,
   input  logic [23:0] req_latency,
   input  logic [47:0] req_now_time,
   output logic        rsp_valid,
   output logic [2:0]  rsp_path_out,
   output logic [31:0] rsp_throughput,
   output logic [16:0] rsp_efficiency,
   output logic [14:0] rsp_loss_percent,
   output logic [23:0] rsp_mean_latency,
   output logic [23:0] rsp_latency_deviation,
   output logic [19:0] rsp_median_latency,
   output logic [19:0] rsp_p90_latency,
   output logic [19:0] rsp_p99_latency,
   output logic [23:0] rsp_least_latency,
   output logic [23:0] rsp_greatest_latency
);
   import pplhm_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       lat_en_ff;

   // latency enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_en_ff <= 1'b1;
      end else if (csr_we) begin
         lat_en_ff <= csr_wdata;
      end
   end

   pplhm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pplhm_dp #(
      .PATH_COUNT (PATH_COUNT),
      .BIN_COUNT  (BIN_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .lat_en            (lat_en_ff),
      .action            (req_action),
      .path_id           (req_path_id),
      .info_bits         (req_info_bits),
      .latency           (req_latency),
      .now_time          (req_now_time),
      .out_valid         (rsp_valid),
      .path_out          (rsp_path_out),
      .throughput        (rsp_throughput),
      .efficiency        (rsp_efficiency),
      .loss_percent      (rsp_loss_percent),
      .mean_latency      (rsp_mean_latency),
      .latency_deviation (rsp_latency_deviation),
      .median_latency    (rsp_median_latency),
      .p90_latency       (rsp_p90_latency),
      .p99_latency       (rsp_p99_latency),
      .least_latency     (rsp_least_latency),
      .greatest_latency  (rsp_greatest_latency)
   );

`ifndef ASSERT_OFF
   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
   a_efficiency_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_efficiency <= 17'd65536) else $error("efficiency range");
   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_loss_percent <= 15'd25600) else $error("loss range");
`endif

endmodule

### verif/tb_per_path_latency_histogram_monitor.sv
`timescale 1ns / 100ps

module tb_per_path_latency_histogram_monitor;
   import pplhm_pkg::*;

   localparam int  NumPaths   = 5;
   localparam int  NumBins    = 32;
   localparam longint CycleLimit = 4000000;

   typedef struct packed {
      logic [2:0]  path_out;
      logic [31:0] throughput;
      logic [16:0] efficiency;
      logic [14:0] loss_percent;
      logic [23:0] mean_latency;
      logic [23:0] latency_deviation;
      logic [19:0] median_latency;
      logic [19:0] p90_latency;
      logic [19:0] p99_latency;
      logic [23:0] least_latency;
      logic [23:0] greatest_latency;
   } metrics_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic [1:0]  req_action = '0;
   logic [2:0]  req_path_id = '0;
   logic [23:0] req_info_bits = '0;
   logic [23:0] req_latency = '0;
   logic [47:0] req_now_time = '0;
   logic        rsp_valid;
   metrics_type seen;

   per_path_latency_histogram_monitor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_action(req_action), .req_path_id(req_path_id),
      .req_info_bits(req_info_bits), .req_latency(req_latency),
      .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_path_out(seen.path_out),
      .rsp_throughput(seen.throughput), .rsp_efficiency(seen.efficiency),
      .rsp_loss_percent(seen.loss_percent), .rsp_mean_latency(seen.mean_latency),
      .rsp_latency_deviation(seen.latency_deviation),
      .rsp_median_latency(seen.median_latency), .rsp_p90_latency(seen.p90_latency),
      .rsp_p99_latency(seen.p99_latency), .rsp_least_latency(seen.least_latency),
      .rsp_greatest_latency(seen.greatest_latency)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow path statistics
   logic        track_latency;
   logic [31:0] n_delivered [NumPaths];
   logic [47:0] bits_delivered [NumPaths];
   logic [47:0] bits_filtered [NumPaths];
   logic [63:0] lat_sum [NumPaths];
   logic [63:0] lat_sq_sum [NumPaths];
   logic [23:0] lat_min [NumPaths];
   logic [23:0] lat_max [NumPaths];
   logic [31:0] n_samples [NumPaths];
   logic [31:0] hist [NumPaths][NumBins];

   metrics_type metrics_due[$];
   int       mismatches = 0;
   bit       no_gaps = 1'b0;
   longint   cycles = 0;

   function automatic logic [19:0] bin_floor(int i);
      logic [19:0] starts [NumBins] = '{
         20'd1, 20'd2, 20'd3, 20'd4, 20'd6, 20'd10, 20'd15, 20'd23, 20'd36,
         20'd56, 20'd87, 20'd135, 20'd211, 20'd329, 20'd513, 20'd801, 20'd1250,
         20'd1952, 20'd3047, 20'd4758, 20'd7430, 20'd11602, 20'd18117, 20'd28289,
         20'd44174, 20'd68978, 20'd107711, 20'd168193, 20'd262637, 20'd410113,
         20'd640401, 20'd1000000};
      return starts[i];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= {64'd0, v}) r = t[63:0];
      end
      return r;
   endfunction

   function automatic logic [19:0] pct_bin(int p, int pct);
      logic [63:0] goal;
      logic [63:0] run;
      run = '0;
      if (n_samples[p] == 0) return '0;
      goal = 64'(n_samples[p]) * pct / 100;
      for (int i = 0; i < NumBins; i++) begin
         run += hist[p][i];
         if (run > goal) return bin_floor(i);
      end
      return (lat_max[p] > 24'd1000000) ? 20'd1000000 : lat_max[p][19:0];
   endfunction

   task automatic clear_stats();
      track_latency = 1'b1;
      for (int p = 0; p < NumPaths; p++) begin
         n_delivered[p] = '0; bits_delivered[p] = '0; bits_filtered[p] = '0;
         lat_sum[p] = '0; lat_sq_sum[p] = '0; lat_min[p] = '1; lat_max[p] = '0;
         n_samples[p] = '0;
         for (int i = 0; i < NumBins; i++) hist[p][i] = '0;
      end
   endtask

   // update shadow state for one event and queue the metrics it reports
   task automatic account_event(action_type act, logic [2:0] path, logic [23:0] info,
                                logic [23:0] lat, logic [47:0] now);
      int p;
      int b;
      logic [64:0] s;
      logic [127:0] d, f, tot, n, m, msq, mc, q;
      metrics_type r;
      if (path >= NumPaths) return;
      p = path;
      if (act == ACT_DELIVERED) begin
         if (n_delivered[p] != '1) n_delivered[p]++;
         s = bits_delivered[p] + info;
         bits_delivered[p] = (s > 65'hFFFF_FFFF_FFFF) ? '1 : s[47:0];
         if (track_latency && lat != 0) begin
            b = 0;
            for (int i = 1; i < NumBins; i++) if (lat >= bin_floor(i)) b = i;
            s = lat_sum[p] + lat;
            lat_sum[p] = s[64] ? '1 : s[63:0];
            s = lat_sq_sum[p] + 64'(lat) * 64'(lat);
            lat_sq_sum[p] = s[64] ? '1 : s[63:0];
            if (lat < lat_min[p]) lat_min[p] = lat;
            if (lat > lat_max[p]) lat_max[p] = lat;
            if (hist[p][b] != '1) hist[p][b]++;
            if (n_samples[p] != '1) n_samples[p]++;
         end
      end else if (act == ACT_FILTERED) begin
         s = bits_filtered[p] + info;
         bits_filtered[p] = (s > 65'hFFFF_FFFF_FFFF) ? '1 : s[47:0];
      end
      d = bits_delivered[p];
      f = bits_filtered[p];
      tot = d + f;
      n = n_delivered[p];
      r = '0;
      r.path_out = path;
      if (now != 0) begin
         q = d * 15625 / (128'(now) * 4);
         r.throughput = (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
      end
      if (tot != 0) begin
         q = d * 65536 / tot;
         r.efficiency = q[16:0];
         q = f * 25600 / tot;
         r.loss_percent = q[14:0];
      end
      if (n != 0) begin
         m = lat_sum[p] / n;
         msq = lat_sq_sum[p] / n;
         mc = (m > 128'hFFFF_FFFF) ? 128'hFFFF_FFFF : m;
         q = (msq > mc * mc) ? root_floor(64'(msq - mc * mc)) : '0;
         r.mean_latency = (m > 128'hFF_FFFF) ? '1 : m[23:0];
         r.latency_deviation = (q > 128'hFF_FFFF) ? '1 : q[23:0];
         r.median_latency = pct_bin(p, 50);
         r.p90_latency = pct_bin(p, 90);
         r.p99_latency = pct_bin(p, 99);
      end
      r.least_latency = lat_min[p];
      r.greatest_latency = lat_max[p];
      metrics_due.push_back(r);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // compare each result transfer with the oldest pending metrics
   always @(posedge clock) begin
      metrics_type w;
      if (!reset && rsp_valid) begin
         if (metrics_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result expected none actual path %0d",
                     $time, seen.path_out);
         end else begin
            w = metrics_due.pop_front();
            check_field("path_out", w.path_out, seen.path_out);
            check_field("throughput", w.throughput, seen.throughput);
            check_field("efficiency", w.efficiency, seen.efficiency);
            check_field("loss_percent", w.loss_percent, seen.loss_percent);
            check_field("mean_latency", w.mean_latency, seen.mean_latency);
            check_field("latency_deviation", w.latency_deviation, seen.latency_deviation);
            check_field("median_latency", w.median_latency, seen.median_latency);
            check_field("p90_latency", w.p90_latency, seen.p90_latency);
            check_field("p99_latency", w.p99_latency, seen.p99_latency);
            check_field("least_latency", w.least_latency, seen.least_latency);
            check_field("greatest_latency", w.greatest_latency, seen.greatest_latency);
         end
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // hold start high until the event transfers, with random gaps ahead of it
   task automatic send_event(action_type act, logic [2:0] path, logic [23:0] info,
                             logic [23:0] lat, logic [47:0] now);
      if (!no_gaps && $urandom_range(99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_action <= act;
      req_path_id <= path;
      req_info_bits <= info;
      req_latency <= lat;
      req_now_time <= now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      account_event(act, path, info, lat, now);
   endtask

   // drain, then write the enable register
   task automatic write_enable(logic val);
      start <= 1'b0;
      @(posedge clock);
      while (metrics_due.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      track_latency = val;
   endtask

   function automatic logic [23:0] rand_latency();
      if ($urandom_range(9) == 0) return '0;
      return 24'($urandom_range(1, (1 << $urandom_range(1, 24)) - 1));
   endfunction

   function automatic logic [47:0] rand_now();
      case ($urandom_range(3))
         0: return 48'($urandom_range(0, 1000));
         1: return {$urandom, $urandom};
         default: return 48'($urandom);
      endcase
   endfunction

   task automatic test_extremes();
      send_event(ACT_DELIVERED, 3'd0, 24'd0, 24'd0, 48'd0);
      send_event(ACT_DELIVERED, 3'd0, '1, 24'd1, 48'd1);
      send_event(ACT_DELIVERED, 3'd0, '1, '1, '1);
      send_event(ACT_DELIVERED, 3'd0, 24'd100, 24'd1000000, 48'd5);
      send_event(ACT_DELIVERED, 3'd0, 24'd100, 24'd999999, 48'd5);
      send_event(ACT_FILTERED, 3'd0, '1, '1, 48'd1000);
      send_event(ACT_BOTTLENECK, 3'd0, '1, 24'd55, 48'd1000);
      send_event(ACT_SPARE, 3'd0, '1, 24'd55, 48'd0);
      send_event(ACT_FILTERED, 3'd1, 24'd500, 24'd0, 48'd10);
      send_event(ACT_BOTTLENECK, 3'd2, 24'd0, 24'd0, 48'd0);
      send_event(ACT_DELIVERED, 3'd3, 24'h5A5A5A, 24'hA5A5A5, 48'hAAAA_AAAA_AAAA);
      send_event(ACT_DELIVERED, 3'd4, 24'hA5A5A5, 24'h5A5A5A, 48'h5555_5555_5555);
      // out-of-range paths drop silently
      send_event(ACT_DELIVERED, 3'd5, '1, '1, 48'd1);
      send_event(ACT_FILTERED, 3'd6, '1, 24'd7, 48'd1);
      send_event(ACT_DELIVERED, 3'd7, '1, 24'd7, 48'd1);
      for (int i = 0; i < 6; i++)
         send_event(ACT_DELIVERED, 3'd4, 24'd1, 24'(bin_floor(i * 6)), 48'd77);
   endtask

   task automatic test_latency_disabled();
      write_enable(1'b0);
      for (int i = 0; i < 30; i++)
         send_event(action_type'($urandom_range(0, 2)), 3'($urandom_range(0, 4)),
                    24'($urandom), rand_latency(), rand_now());
      write_enable(1'b1);
   endtask

   task automatic test_random(int count);
      logic [2:0] path;
      for (int i = 0; i < count; i++) begin
         no_gaps = (i >= count / 3 && i < count / 2);
         path = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         send_event(($urandom_range(9) < 6) ? ACT_DELIVERED
                                            : action_type'($urandom_range(1, 3)),
                    path, 24'($urandom), rand_latency(), rand_now());
         if (i == count / 2) write_enable(1'b0);
         if (i == count / 2 + 80) write_enable(1'b1);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      clear_stats();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_latency_disabled();
      test_random(1650);
      start <= 1'b0;
      while (metrics_due.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
